// ===== rtl/ugce_pkg.sv =====
// ugce_pkg: shared types, codes and descriptor tables for the gamepad control endpoint
// no dependencies
`default_nettype none
package ugce_pkg;

    localparam int PAD_BYTES = 20;

    typedef enum logic [1:0] {
        CMD_SETUP = 2'd0,
        CMD_IN    = 2'd1,
        CMD_OUT   = 2'd2,
        CMD_PAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STALL = 2'd1,
        ST_NORSP = 2'd2,
        ST_NAK   = 2'd3
    } t_status;

    // reply sources for the buffer fill
    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_CFGV = 3'd1,
        SRC_DEV  = 3'd2,
        SRC_CONF = 3'd3,
        SRC_PAD  = 3'd4,
        SRC_XID  = 3'd5,
        SRC_FF   = 3'd6
    } t_src;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_RDWAIT,
        S_STREAM,
        S_SINGLE
    } t_state;

    function automatic logic [7:0] dev_rom(input logic [4:0] i);
        logic [7:0] r;
        unique case (i)
            5'd0: r = 8'h12;  5'd1: r = 8'h01;  5'd2: r = 8'h10;  5'd3: r = 8'h01;
            5'd7: r = 8'h08;  5'd8: r = 8'h5E;  5'd9: r = 8'h04;  5'd10: r = 8'h89;
            5'd11: r = 8'h02; 5'd12: r = 8'h21; 5'd13: r = 8'h01; 5'd17: r = 8'h01;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cfg_rom(input logic [4:0] i);
        logic [7:0] r;
        unique case (i)
            5'd0: r = 8'h09;  5'd1: r = 8'h02;  5'd2: r = 8'h20;  5'd4: r = 8'h01;
            5'd5: r = 8'h01;  5'd7: r = 8'h80;  5'd8: r = 8'h32;  5'd9: r = 8'h09;
            5'd10: r = 8'h04; 5'd13: r = 8'h02; 5'd14: r = 8'h58; 5'd15: r = 8'h42;
            5'd18: r = 8'h07; 5'd19: r = 8'h05; 5'd20: r = 8'h81; 5'd21: r = 8'h03;
            5'd22: r = 8'h20; 5'd24: r = 8'h04; 5'd25: r = 8'h07; 5'd26: r = 8'h05;
            5'd27: r = 8'h02; 5'd28: r = 8'h03; 5'd29: r = 8'h20; 5'd31: r = 8'h04;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xid_rom(input logic [4:0] i);
        logic [7:0] r;
        unique case (i)
            5'd0: r = 8'h10; 5'd1: r = 8'h42; 5'd2: r = 8'h00; 5'd3: r = 8'h01;
            5'd4: r = 8'h01; 5'd5: r = 8'h02; 5'd6: r = 8'(PAD_BYTES); 5'd7: r = 8'h06;
            default: r = 8'hFF;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic       fill_start;  // latch decode, start buffer fill
        logic       rd_start;    // start reading at reply offset (pad byte 0 for endpoint 1)
        logic       rd_next;     // advance read pointer
        logic       pad_write;
        logic       setup_ok;    // apply accepted setup state
        logic       short_stall;
        logic       status_end;  // zero-length status stage
        logic       ctrl_in;     // control IN consumed bytes
    } t_cmdbus;

    typedef struct packed {
        logic       fill_done;
        logic       addr_ok;
        logic       stall;
        logic [6:0] n_bytes;     // bytes this IN will move
    } t_stsbus;

endpackage
`default_nettype wire

// ===== rtl/ugce_if.sv =====
// ugce_if: valid/ready channel interfaces for input and result beats
// depends on nothing
`default_nettype none
interface ugce_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  target_address;
    logic [3:0]  endpoint_number;
    logic [63:0] setup_packet;
    logic [6:0]  requested_length;
    logic [4:0]  report_index;
    logic [7:0]  report_value;
    modport source (output valid, command, target_address, endpoint_number, setup_packet,
                    requested_length, report_index, report_value, input ready);
    modport sink (input valid, command, target_address, endpoint_number, setup_packet,
                  requested_length, report_index, report_value, output ready);
endinterface

interface ugce_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [6:0] bytes_moved;
    logic       final_result;
    modport source (output valid, status, data_byte, data_valid, bytes_moved, final_result,
                    input ready);
    modport sink (input valid, status, data_byte, data_valid, bytes_moved, final_result,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/ugce_ram.sv =====
// ugce_ram: generic single-port-write, one-read RAM with registered read
// no dependencies
`default_nettype none
module ugce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ugce_datapath.sv =====
// ugce_datapath: request decode, device state, pad report, reply buffer fill and read
// depends on ugce_pkg, ugce_ram
`default_nettype none
module ugce_datapath
    import ugce_pkg::*;
#(
    parameter int CONTROL_BUFFER_BYTES = 64,
    parameter int MAX_TRANSFER_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmdbus     i_cmd,
    input  wire logic [6:0]  i_target_address,
    input  wire logic [3:0]  i_endpoint_number,
    input  wire logic [63:0] i_setup_packet,
    input  wire logic [6:0]  i_requested_length,
    input  wire logic [4:0]  i_report_index,
    input  wire logic [7:0]  i_report_value,
    output t_stsbus          o_sts,
    output logic [7:0]       o_rd_byte
);
    localparam int AW = $clog2(CONTROL_BUFFER_BYTES);

    logic [6:0] r_dev_addr, r_pend_addr;
    logic       r_pend_valid, r_stall;
    logic [7:0] r_cfg_val;
    logic [6:0] r_rlen, r_roff;
    logic [7:0] r_pad [PAD_BYTES];
    logic [7:0] r_pad_q;
    logic       r_from_pad;

    // fill
    t_src       r_src;
    logic [6:0] r_fcnt, r_flen;
    logic [7:0] r_fn;

    // decode of setup packet
    logic [7:0]  rt, rq, hi, wvl;
    logic [15:0] wl;
    logic        acc;
    t_src        dsrc;
    logic [7:0]  dlen, dfn;
    logic        set_addr, set_cfg;

    always_comb begin
        rt = i_setup_packet[7:0];
        rq = i_setup_packet[15:8];
        wvl = i_setup_packet[23:16];
        hi = i_setup_packet[31:24];
        wl = i_setup_packet[63:48];
        acc = 1'b0; dsrc = SRC_ZERO; dlen = 8'd0; dfn = 8'd0;
        set_addr = 1'b0; set_cfg = 1'b0;
        if (rt[6:0] == 7'h00) begin
            case (rq)
                8'h00: begin acc = 1'b1; dlen = 8'd2; end
                8'h05: begin acc = 1'b1; set_addr = 1'b1; end
                8'h06: begin
                    if (hi == 8'h01) begin acc = 1'b1; dsrc = SRC_DEV; dlen = 8'd18; end
                    else if (hi == 8'h02) begin acc = 1'b1; dsrc = SRC_CONF; dlen = 8'd32; end
                end
                8'h08: begin acc = 1'b1; dsrc = SRC_CFGV; dlen = 8'd1; end
                8'h09: begin acc = 1'b1; set_cfg = 1'b1; end
                8'h01, 8'h03: acc = 1'b1;
                default: ;
            endcase
        end
        if (!acc && rt[6:5] == 2'b00 && rt[4:0] != 5'd0) begin
            if (rq == 8'h00) begin acc = 1'b1; dlen = 8'd2; end
            else if (rq == 8'h0A) begin acc = 1'b1; dlen = 8'd1; end
            else if (rq == 8'h0B) acc = 1'b1;
        end
        if (!acc && rt[6:5] == 2'b01 && rt[4:0] == 5'd1 && rq == 8'h01 && hi == 8'h01) begin
            acc = 1'b1; dsrc = SRC_PAD; dlen = 8'(PAD_BYTES);
        end
        if (!acc && rt[6:5] == 2'b10 && rt[4:0] == 5'd1) begin
            if (rq == 8'h06 && hi == 8'h42) begin acc = 1'b1; dsrc = SRC_XID; dlen = 8'd16; end
            else if (rq == 8'h01) begin
                acc = 1'b1; dsrc = SRC_FF;
                dfn = (hi == 8'h02) ? 8'd6 : 8'(PAD_BYTES);
                dlen = dfn;
            end
        end
        if (16'(dlen) > wl) dlen = wl[7:0];
    end

    // fill data
    logic [7:0] fbyte;
    logic       fwe;
    always_comb begin
        case (r_src)
            SRC_CFGV: fbyte = r_cfg_val;
            SRC_DEV:  fbyte = dev_rom(r_fcnt[4:0]);
            SRC_CONF: fbyte = cfg_rom(r_fcnt[4:0]);
            SRC_PAD:  fbyte = r_pad_q;
            SRC_XID:  fbyte = xid_rom(r_fcnt[4:0]);
            SRC_FF:   fbyte = (r_fcnt == 7'd0) ? 8'h00 : (r_fcnt == 7'd1) ? r_fn : 8'hFF;
            default:  fbyte = 8'h00;
        endcase
        fwe = r_fcnt < r_flen;
    end

    // pad byte read, registered; used for pad reply fill and endpoint 1 IN
    logic [6:0] r_rptr;
    logic [4:0] pad_ra;
    always_comb begin
        if (i_cmd.fill_start) pad_ra = 5'd0;
        else if (r_from_pad && !fwe) pad_ra = r_rptr[4:0];
        else pad_ra = r_fcnt[4:0] + 5'd1;
    end
    always_ff @(posedge i_clk) begin
        r_pad_q <= (pad_ra < 5'(PAD_BYTES)) ? r_pad[pad_ra] : 8'h00;
    end

    logic [AW-1:0] ram_ra;
    logic [7:0]    ram_q;
    assign ram_ra = AW'(r_rptr);
    ugce_ram #(.WIDTH(8), .DEPTH(CONTROL_BUFFER_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(fwe && ({1'b0, r_fcnt} < 8'(CONTROL_BUFFER_BYTES))),
        .i_waddr(AW'(r_fcnt)), .i_wdata(fbyte), .i_raddr(ram_ra), .o_rdata(ram_q)
    );
    assign o_rd_byte = r_from_pad ? r_pad_q : ram_q;

    // IN byte count
    logic [6:0] eff, avail;
    always_comb begin
        eff = (i_requested_length > 7'(MAX_TRANSFER_BYTES)) ? 7'(MAX_TRANSFER_BYTES)
                                                             : i_requested_length;
        if (i_endpoint_number == 4'd1) avail = 7'(PAD_BYTES);
        else avail = (r_rlen > r_roff) ? r_rlen - r_roff : 7'd0;
        o_sts.n_bytes = (avail > eff) ? eff : avail;
        o_sts.fill_done = !fwe;
        o_sts.addr_ok = i_target_address == r_dev_addr;
        o_sts.stall = r_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_from_pad <= i_endpoint_number == 4'd1;
            r_rptr <= (i_endpoint_number == 4'd1) ? 7'd0 : r_roff;
        end else if (i_cmd.rd_next) begin
            r_rptr <= r_rptr + 7'd1;
        end
        if (!i_rst_n) begin
            r_dev_addr <= '0; r_pend_addr <= '0; r_pend_valid <= 1'b0;
            r_cfg_val <= '0; r_stall <= 1'b0; r_rlen <= '0; r_roff <= '0;
            r_fcnt <= '0; r_flen <= '0; r_src <= SRC_ZERO;
            for (int k = 0; k < PAD_BYTES; k++) r_pad[k] <= (k == 1) ? 8'(PAD_BYTES) : 8'h00;
        end else begin
            if (fwe) r_fcnt <= r_fcnt + 7'd1;
            if (i_cmd.pad_write && i_report_index < 5'(PAD_BYTES))
                r_pad[i_report_index] <= i_report_value;
            if (i_cmd.fill_start) begin
                r_roff <= '0;
                r_pend_valid <= set_addr;
                if (set_addr) r_pend_addr <= wvl[6:0];
                if (set_cfg) r_cfg_val <= wvl;
                r_stall <= !acc;
                r_src <= dsrc; r_fn <= dfn; r_fcnt <= '0;
                r_flen <= acc ? ((dlen > 8'(CONTROL_BUFFER_BYTES)) ?
                                 7'(CONTROL_BUFFER_BYTES) : dlen[6:0]) : 7'd0;
                r_rlen <= acc ? dlen[6:0] : 7'd0;
            end
            if (i_cmd.ctrl_in) r_roff <= r_roff + o_sts.n_bytes;
            if (i_cmd.status_end) begin
                if (r_pend_valid) begin
                    r_dev_addr <= r_pend_addr; r_pend_valid <= 1'b0;
                end
                r_stall <= 1'b0; r_rlen <= '0; r_roff <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ugce_control.sv =====
// ugce_control: transaction sequencer and output register
// depends on ugce_pkg
`default_nettype none
module ugce_control
    import ugce_pkg::*;
#(
    parameter int MAX_TRANSFER_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [3:0] i_endpoint_number,
    input  wire logic [6:0] i_requested_length,
    input  wire t_stsbus    i_sts,
    input  wire logic [7:0] i_rd_byte,
    output t_cmdbus         o_cmd,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_data_byte,
    output logic            o_data_valid,
    output logic [6:0]      o_bytes_moved,
    output logic            o_final_result
);
    t_state r_state, n_state;
    logic [6:0] r_n, n_n, r_i, n_i;
    logic r_ov, n_ov;
    logic [1:0] r_st, n_st; logic [7:0] r_db, n_db; logic r_dv, n_dv;
    logic [6:0] r_bm, n_bm; logic r_fin, n_fin;
    logic acc, slot;

    assign o_valid = r_ov; assign o_status = r_st; assign o_data_byte = r_db;
    assign o_data_valid = r_dv; assign o_bytes_moved = r_bm; assign o_final_result = r_fin;
    assign slot = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_n <= '0; r_i <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_n <= n_n; r_i <= n_i;
        end
        r_st <= n_st; r_db <= n_db; r_dv <= n_dv; r_bm <= n_bm; r_fin <= n_fin;
    end

    always_comb begin
        n_state = r_state; n_ov = r_ov && !i_ready; n_n = r_n; n_i = r_i;
        n_st = r_st; n_db = r_db; n_dv = r_dv; n_bm = r_bm; n_fin = r_fin;
        o_cmd = '0;
        o_in_ready = 1'b0;
        acc = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = slot;
                acc = i_in_valid && slot;
                if (acc) begin
                    n_st = ST_OK; n_db = '0; n_dv = 1'b0; n_bm = '0; n_fin = 1'b1;
                    if (i_command == CMD_PAD) begin
                        o_cmd.pad_write = 1'b1;
                    end else if (!i_sts.addr_ok) begin
                        n_st = ST_NORSP; n_ov = 1'b1;
                    end else if (i_command == CMD_SETUP) begin
                        if (i_requested_length < 7'd8) begin
                            n_st = ST_STALL; n_ov = 1'b1;
                        end else begin
                            o_cmd.fill_start = 1'b1; n_bm = 7'd8;
                            n_state = S_FILL;
                        end
                    end else if (i_sts.stall) begin
                        n_st = ST_STALL; n_ov = 1'b1;
                    end else if (i_command == CMD_OUT) begin
                        o_cmd.status_end = i_requested_length == 7'd0;
                        n_bm = (i_requested_length > 7'(MAX_TRANSFER_BYTES)) ?
                               7'(MAX_TRANSFER_BYTES) : i_requested_length;
                        n_ov = 1'b1;
                    end else if (i_endpoint_number > 4'd1) begin
                        n_st = ST_NAK; n_ov = 1'b1;
                    end else begin
                        o_cmd.ctrl_in = i_endpoint_number == 4'd0;
                        o_cmd.status_end = i_requested_length == 7'd0;
                        if (i_sts.n_bytes == 7'd0) begin
                            n_ov = 1'b1;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                            n_n = i_sts.n_bytes; n_i = '0;
                            n_state = S_RDWAIT;
                        end
                    end
                end
            end
            S_FILL: begin
                if (i_sts.fill_done) n_state = S_SINGLE;
            end
            S_SINGLE: begin
                if (slot) begin n_ov = 1'b1; n_state = S_IDLE; end
            end
            S_RDWAIT: begin
                n_state = S_STREAM;
            end
            S_STREAM: begin
                if (slot) begin
                    n_ov = 1'b1; n_st = ST_OK; n_db = i_rd_byte; n_dv = 1'b1;
                    n_bm = r_n; n_fin = (r_i + 7'd1 == r_n);
                    n_i = r_i + 7'd1; o_cmd.rd_next = 1'b1;
                    n_state = (r_i + 7'd1 == r_n) ? S_IDLE : S_RDWAIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_dv_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_dv) |-> r_db == 8'd0) else $error("data without valid");
    a_stream_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_dv) |-> (r_fin == (r_i == r_n))) else $error("final marker wrong");
`endif
endmodule
`default_nettype wire

// ===== rtl/usb_gamepad_control_endpoint.sv =====
// usb_gamepad_control_endpoint: top level of the gamepad control/report endpoint
// depends on ugce_pkg, ugce_if, ugce_control, ugce_datapath
`default_nettype none
//  channel  | dir | payload
//  i_in     | in  | command, address, endpoint, setup packet, length, pad byte
//  o_out    | out | status, data byte, data valid, bytes moved, final marker
//
//  one transaction is taken at a time; a pad write or a short reply is done in S_IDLE
//  an accepted SETUP fills the reply RAM, one buffer byte per cycle, before its
//  result beat
//  an IN of n bytes gives n beats; each byte waits in S_RDWAIT for a registered read
//  reset is synchronous and clears all device state and the pad report, but for pad byte 1 (the report length)
//  a stalled output register holds and blocks the next beat
module usb_gamepad_control_endpoint
    import ugce_pkg::*;
#(
    parameter int CONTROL_BUFFER_BYTES = 64,
    parameter int MAX_TRANSFER_BYTES = 64
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ugce_in_if.sink    i_in,
    ugce_out_if.source o_out
);
    t_cmdbus    cmd;
    t_stsbus    sts;
    logic [7:0] rd_byte;

    // sequencer decides the result type, datapath owns all device state
    ugce_control #(
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_command(i_in.command), .i_endpoint_number(i_in.endpoint_number),
        .i_requested_length(i_in.requested_length),
        .i_sts(sts), .i_rd_byte(rd_byte), .o_cmd(cmd),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_status(o_out.status), .o_data_byte(o_out.data_byte),
        .o_data_valid(o_out.data_valid), .o_bytes_moved(o_out.bytes_moved),
        .o_final_result(o_out.final_result)
    );

    ugce_datapath #(
        .CONTROL_BUFFER_BYTES(CONTROL_BUFFER_BYTES),
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_target_address(i_in.target_address),
        .i_endpoint_number(i_in.endpoint_number), .i_setup_packet(i_in.setup_packet),
        .i_requested_length(i_in.requested_length), .i_report_index(i_in.report_index),
        .i_report_value(i_in.report_value), .o_sts(sts), .o_rd_byte(rd_byte)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for usb_gamepad_control_endpoint
// depends on ugce_pkg, ugce_if and the block's rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ugce_pkg::*;

    localparam int MAX_XFER = 64;
    localparam int BUF_BYTES = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    // one expected result beat
    typedef struct {
        t_status    status;
        logic [7:0] data_byte;
        logic       data_valid;
        logic [6:0] bytes_moved;
        logic       final_result;
    } t_beat;

    // one row of stimulus; chk set when the expected beat is typed in
    typedef struct {
        t_cmd        cmd;
        logic [6:0]  addr;
        logic [3:0]  ep;
        logic [63:0] pkt;
        logic [6:0]  len;
        logic [4:0]  idx;
        logic [7:0]  val;
        logic        chk;
        t_status     st;
        logic [6:0]  moved;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ugce_in_if  in_ch();
    ugce_out_if out_ch();

    usb_gamepad_control_endpoint dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // device model state
    logic [6:0] dev_addr, pend_addr;
    logic       pend_valid, stalled;
    logic [7:0] cfg_value;
    logic [7:0] reply [BUF_BYTES];
    int         reply_len, reply_pos;
    logic [7:0] pad [PAD_BYTES];

    t_beat expected_beats[$];
    int    errors = 0;
    int    mismatches = 0;
    int    idle_pct = 0;      // sender idle chance
    int    stall_pct = 0;     // receiver stall chance
    bit    hold_off = 1'b0;
    int    quiet_cycles = 0;
    bit    done = 1'b0;

    function automatic logic [7:0] dev_desc(int i);
        logic [7:0] t [18] = '{8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08,
            8'h5E, 8'h04, 8'h89, 8'h02, 8'h21, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
        return t[i];
    endfunction

    function automatic logic [7:0] conf_desc(int i);
        logic [7:0] t [32] = '{8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80,
            8'h32, 8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h58, 8'h42, 8'h00, 8'h00,
            8'h07, 8'h05, 8'h81, 8'h03, 8'h20, 8'h00, 8'h04,
            8'h07, 8'h05, 8'h02, 8'h03, 8'h20, 8'h00, 8'h04};
        return t[i];
    endfunction

    function automatic logic [7:0] xid_desc(int i);
        logic [7:0] t [8] = '{8'h10, 8'h42, 8'h00, 8'h01, 8'h01, 8'h02, 8'd20, 8'h06};
        return i < 8 ? t[i] : 8'hFF;
    endfunction

    function automatic void model_reset();
        dev_addr = '0; pend_addr = '0; pend_valid = 1'b0; stalled = 1'b0;
        cfg_value = '0; reply_len = 0; reply_pos = 0;
        foreach (reply[i]) reply[i] = '0;
        foreach (pad[i]) pad[i] = '0;
        pad[1] = 8'(PAD_BYTES);
    endfunction

    function automatic void push_beat(t_status st, logic [7:0] b, logic v, int n, logic f);
        t_beat e;
        e.status = st; e.data_byte = b; e.data_valid = v;
        e.bytes_moved = 7'(n); e.final_result = f;
        expected_beats.push_back(e);
    endfunction

    // request decode; returns 1 when accepted, reply filled
    function automatic bit decode_request(logic [63:0] pkt);
        logic [7:0] rt, rq, hi;
        logic [15:0] wv;
        int n;
        rt = pkt[7:0]; rq = pkt[15:8]; wv = pkt[31:16]; hi = wv[15:8];
        reply_len = 0;
        if (rt[6:0] == 7'h00) begin
            case (rq)
                8'h00: begin
                    reply[0] = 0; reply[1] = 0; reply_len = 2; return 1;
                end
                8'h05: begin
                    pend_addr = wv[6:0]; pend_valid = 1'b1; return 1;
                end
                8'h06: begin
                    if (hi == 8'h01) begin
                        for (int i = 0; i < 18; i++) reply[i] = dev_desc(i);
                        reply_len = 18; return 1;
                    end
                    if (hi == 8'h02) begin
                        for (int i = 0; i < 32; i++) reply[i] = conf_desc(i);
                        reply_len = 32; return 1;
                    end
                end
                8'h08: begin
                    reply[0] = cfg_value; reply_len = 1; return 1;
                end
                8'h09: begin
                    cfg_value = wv[7:0]; return 1;
                end
                8'h01, 8'h03: return 1;
                default: ;
            endcase
        end
        if (rt[6:5] == 2'b00 && rt[4:0] != 5'd0) begin
            if (rq == 8'h00) begin
                reply[0] = 0; reply[1] = 0; reply_len = 2; return 1;
            end
            if (rq == 8'h0A) begin
                reply[0] = 0; reply_len = 1; return 1;
            end
            if (rq == 8'h0B) return 1;
        end
        if (rt[6:5] == 2'b01 && rt[4:0] == 5'd1 && rq == 8'h01 && hi == 8'h01) begin
            for (int i = 0; i < PAD_BYTES; i++) reply[i] = pad[i];
            reply_len = PAD_BYTES; return 1;
        end
        if (rt[6:5] == 2'b10 && rt[4:0] == 5'd1) begin
            if (rq == 8'h06 && hi == 8'h42) begin
                for (int i = 0; i < 16; i++) reply[i] = xid_desc(i);
                reply_len = 16; return 1;
            end
            if (rq == 8'h01) begin
                n = (hi == 8'h02) ? 6 : PAD_BYTES;
                for (int i = 0; i < n; i++) reply[i] = 8'hFF;
                reply[0] = 8'h00; reply[1] = 8'(n);
                reply_len = n; return 1;
            end
        end
        reply_len = 0;
        return 0;
    endfunction

    function automatic void status_stage(int want);
        if (want != 0) return;
        if (pend_valid) begin
            dev_addr = pend_addr; pend_valid = 1'b0;
        end
        stalled = 1'b0; reply_len = 0; reply_pos = 0;
    endfunction

    // works out the result beats of one transaction
    function automatic void predict_transaction(t_row r);
        int want, eff, n;
        logic [7:0] bytes [MAX_XFER];
        want = r.len; eff = want > MAX_XFER ? MAX_XFER : want;
        if (r.cmd == CMD_PAD) begin
            if (r.idx < PAD_BYTES) pad[r.idx] = r.val;
            return;
        end
        if (r.addr != dev_addr) begin
            push_beat(ST_NORSP, 0, 0, 0, 1); return;
        end
        if (r.cmd == CMD_SETUP) begin
            if (want < 8) begin
                push_beat(ST_STALL, 0, 0, 0, 1); return;
            end
            reply_len = 0; reply_pos = 0; pend_valid = 1'b0; stalled = 1'b0;
            if (decode_request(r.pkt)) begin
                if (reply_len > r.pkt[63:48]) reply_len = r.pkt[63:48];
            end else begin
                stalled = 1'b1; reply_len = 0;
            end
            push_beat(ST_OK, 0, 0, 8, 1);
            return;
        end
        if (stalled) begin
            push_beat(ST_STALL, 0, 0, 0, 1); return;
        end
        if (r.cmd == CMD_OUT) begin
            status_stage(want);
            push_beat(ST_OK, 0, 0, eff, 1);
            return;
        end
        if (r.ep != 0) begin
            if (r.ep != 1) begin
                push_beat(ST_NAK, 0, 0, 0, 1); return;
            end
            n = PAD_BYTES > eff ? eff : PAD_BYTES;
            for (int i = 0; i < n; i++) bytes[i] = pad[i];
        end else begin
            n = reply_len > reply_pos ? reply_len - reply_pos : 0;
            if (n > eff) n = eff;
            for (int i = 0; i < n; i++) bytes[i] = reply[reply_pos + i];
            reply_pos += n;
        end
        status_stage(want);
        if (n == 0) begin
            push_beat(ST_OK, 0, 0, 0, 1); return;
        end
        for (int i = 0; i < n; i++) push_beat(ST_OK, bytes[i], 1, n, i == n - 1);
    endfunction

    function automatic logic [63:0] setup_pkt(logic [7:0] rt, logic [7:0] rq,
                                              logic [15:0] wv, logic [15:0] wl);
        return {wl, 16'h0000, wv, rq, rt};
    endfunction

    function automatic t_row make_row(t_cmd c, logic [6:0] a, logic [3:0] e,
                                      logic [63:0] p, logic [6:0] l);
        t_row r;
        r.cmd = c; r.addr = a; r.ep = e; r.pkt = p; r.len = l;
        r.idx = '0; r.val = '0; r.chk = 1'b0; r.st = ST_OK; r.moved = '0;
        return r;
    endfunction

    // drive one transaction and wait for its acceptance
    task automatic send_transaction(t_row r);
        int    before_n;
        t_beat typed;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= r.cmd;
        in_ch.target_address <= r.addr;
        in_ch.endpoint_number <= r.ep;
        in_ch.setup_packet <= r.pkt;
        in_ch.requested_length <= r.len;
        in_ch.report_index <= r.idx;
        in_ch.report_value <= r.val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // accepted at this edge: predict in transaction order
        before_n = expected_beats.size();
        predict_transaction(r);
        if (r.chk) begin
            // the typed-in beat stands in for the predicted one
            if (expected_beats.size() != before_n + 1) begin
                errors++;
                if (mismatches++ < 10)
                    $display("table row gives one beat, prediction gives %0d",
                             expected_beats.size() - before_n);
            end else begin
                typed.status = r.st; typed.data_byte = '0; typed.data_valid = 1'b0;
                typed.bytes_moved = r.moved; typed.final_result = 1'b1;
                expected_beats[expected_beats.size() - 1] = typed;
            end
        end
    endtask

    // random transaction, mostly well-formed control sequences
    function automatic t_row random_transaction();
        t_row r;
        int pick;
        logic [7:0] rt, rq;
        logic [15:0] wv, wl;
        pick = $urandom_range(99);
        r = make_row(CMD_IN, dev_addr, 4'd0, {$urandom, $urandom}, 7'($urandom_range(64)));
        if ($urandom_range(19) == 0) r.addr = 7'($urandom);
        if ($urandom_range(19) == 0) r.len = 7'($urandom_range(127));
        if (pick < 30) begin
            r.cmd = CMD_SETUP;
            r.len = 7'($urandom_range(8, 64));
            case ($urandom_range(9))
                0: begin rt = 8'h80; rq = 8'h06; wv = {8'h01, 8'($urandom)}; end
                1: begin rt = 8'h80; rq = 8'h06; wv = {8'h02, 8'($urandom)}; end
                2: begin rt = 8'hA1; rq = 8'h01; wv = 16'h0100; end
                3: begin rt = 8'hC1; rq = 8'h06; wv = 16'h4200; end
                4: begin rt = 8'hC1; rq = 8'h01; wv = {8'($urandom_range(1, 2)), 8'h00}; end
                5: begin rt = 8'h00; rq = 8'h09; wv = 16'($urandom); end
                6: begin rt = 8'h80; rq = 8'h08; wv = 0; end
                7: begin rt = 8'h00; rq = 8'h05; wv = 16'($urandom_range(0, 3)); end
                8: begin rt = 8'($urandom_range(0, 3)); rq = 8'($urandom_range(0, 11));
                         wv = 16'($urandom); end
                default: begin rt = 8'($urandom); rq = 8'($urandom); wv = 16'($urandom); end
            endcase
            wl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64));
            r.pkt = {wl, 16'($urandom), wv, rq, rt};
        end else if (pick < 70) begin
            r.cmd = CMD_IN;
            r.ep = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1));
            if ($urandom_range(3) == 0) r.len = 0;
        end else if (pick < 85) begin
            r.cmd = CMD_OUT;
            r.ep = 4'($urandom);
            if ($urandom_range(1) == 0) r.len = 0;
        end else begin
            r.cmd = CMD_PAD;
            r.idx = 5'($urandom);
            r.val = 8'($urandom);
        end
        return r;
    endfunction

    // directed table: extremes, every command and each special case
    t_row dir_rows[$];

    initial begin
        t_row r;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_PAD;
        in_ch.target_address = '0;
        in_ch.endpoint_number = '0;
        in_ch.setup_packet = '0;
        in_ch.requested_length = '0;
        in_ch.report_index = '0;
        in_ch.report_value = '0;
        model_reset();

        // wrong address: not responding
        r = make_row(CMD_IN, 7'h7F, 4'hF, '1, 7'h7F); r.chk = 1; r.st = ST_NORSP;
        dir_rows.push_back(r);
        // short setup stalls
        r = make_row(CMD_SETUP, 0, 0, setup_pkt(8'h80, 8'h06, 16'h0100, 16'd64), 7'd7);
        r.chk = 1; r.st = ST_STALL; dir_rows.push_back(r);
        // device descriptor, then read it out over two INs
        r = make_row(CMD_SETUP, 0, 0, setup_pkt(8'h80, 8'h06, 16'h0100, 16'hFFFF), 7'd8);
        r.chk = 1; r.moved = 8; dir_rows.push_back(r);
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd8));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd127));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd5));    // empty IN
        r = make_row(CMD_OUT, 0, 4'd3, 0, 7'd0); r.chk = 1; dir_rows.push_back(r);
        // configuration descriptor clamped by wLength
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'h80, 8'h06, 16'h0200, 16'd9), 7'd64));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd64));
        // refused request stalls later stages
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0, '1, 7'd64));
        r = make_row(CMD_IN, 0, 0, 0, 7'd0); r.chk = 1; r.st = ST_STALL; dir_rows.push_back(r);
        r = make_row(CMD_OUT, 0, 0, 0, 7'd0); r.chk = 1; r.st = ST_STALL; dir_rows.push_back(r);
        // an accepted setup clears the stall
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'h00, 8'h09, 16'h0001, 16'd0), 7'd8));
        // pad writes, one ignored past the end
        r = make_row(CMD_PAD, 0, 0, 0, 0); r.idx = 5'd2; r.val = 8'hFF; dir_rows.push_back(r);
        r = make_row(CMD_PAD, 0, 0, 0, 0); r.idx = 5'd31; r.val = 8'hA5; dir_rows.push_back(r);
        dir_rows.push_back(make_row(CMD_IN, 0, 4'd1, 0, 7'd64));
        r = make_row(CMD_IN, 0, 4'd2, 0, 7'd8); r.chk = 1; r.st = ST_NAK; dir_rows.push_back(r);
        // class and vendor reports
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'hA1, 8'h01, 16'h0100, 16'd64), 7'd8));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd64));
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'hC1, 8'h06, 16'h4200, 16'd64), 7'd8));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd64));
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'hC1, 8'h01, 16'h0200, 16'd64), 7'd8));
        dir_rows.push_back(make_row(CMD_IN, 0, 0, 0, 7'd64));
        // set address 5, applied after the status stage
        dir_rows.push_back(make_row(CMD_SETUP, 0, 0,
                                    setup_pkt(8'h00, 8'h05, 16'h0005, 16'd0), 7'd8));
        r = make_row(CMD_IN, 0, 0, 0, 7'd0); r.chk = 1; dir_rows.push_back(r);
        r = make_row(CMD_OUT, 7'd5, 0, 0, 7'd64); r.chk = 1; r.moved = 64;
        dir_rows.push_back(r);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_transaction(dir_rows[i]);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 84 : (ph == 3) ? 17 : 0;
            stall_pct = (ph == 2) ? 84 : (ph == 3) ? 17 : 0;
            if (ph == 1) hold_off = 1'b1;   // long receiver hold-off while sending
            for (int k = 0; k < 125; k++) send_transaction(random_transaction());
        end
        in_ch.valid <= 1'b0;
        idle_pct = 0; stall_pct = 0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        done = 1'b1;
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int hold_count;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                hold_off <= 1'b0;
                hold_count = 0;
                out_ch.ready <= 1'b0;
                while (hold_count < 300) begin
                    @(posedge i_clk);
                    hold_count++;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result beat: status %0d byte %h",
                             out_ch.status, out_ch.data_byte);
            end else begin
                e = expected_beats.pop_front();
                if (out_ch.status !== e.status || out_ch.data_byte !== e.data_byte ||
                    out_ch.data_valid !== e.data_valid ||
                    out_ch.bytes_moved !== e.bytes_moved ||
                    out_ch.final_result !== e.final_result) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp st %0d byte %h dv %b moved %0d fin %b, got st %0d byte %h dv %b moved %0d fin %b",
                                 e.status, e.data_byte, e.data_valid, e.bytes_moved,
                                 e.final_result, out_ch.status, out_ch.data_byte,
                                 out_ch.data_valid, out_ch.bytes_moved, out_ch.final_result);
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat, and the end of the run
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (done) begin
            if (errors == 0 && expected_beats.size() == 0)
                $display("status: pass");
            else
                $display("status: fail");
            $finish;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end
endmodule
`default_nettype wire
